FILE: design/rcp_pkg.sv
// Package for the rounded corner point pipeline.
// Holds the default widths and the register map; no dependencies.
`default_nettype none

package rcp_pkg;

  // Default coordinate format, signed Q16.16
  localparam int COORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  // APB register map: one register at byte address 0
  localparam int ADDR_BITS = 2;
  localparam logic [ADDR_BITS-1:0] ADDR_DEFAULT_RADIUS = 2'd0;

endpackage

`default_nettype wire

FILE: design/rcp_ifs.sv
// Valid/ready stream interfaces for corner input and fillet output.
// Depends on rcp_pkg for the default coordinate width.
`default_nettype none

interface rcp_corner_if #(parameter int COORD_BITS = rcp_pkg::COORD_BITS_DEF);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] prev_x;
  logic signed [COORD_BITS-1:0] prev_y;
  logic signed [COORD_BITS-1:0] curr_x;
  logic signed [COORD_BITS-1:0] curr_y;
  logic signed [COORD_BITS-1:0] next_x;
  logic signed [COORD_BITS-1:0] next_y;
  logic        [COORD_BITS-2:0] vertex_radius;
  logic                         first_corner;

  modport source (output valid, prev_x, prev_y, curr_x, curr_y, next_x, next_y,
                  vertex_radius, first_corner, input ready);
  modport sink   (input valid, prev_x, prev_y, curr_x, curr_y, next_x, next_y,
                  vertex_radius, first_corner, output ready);
endinterface

interface rcp_fillet_if #(parameter int COORD_BITS = rcp_pkg::COORD_BITS_DEF);
  logic                         valid;
  logic                         ready;
  logic                         rounded;
  logic signed [COORD_BITS-1:0] start_x;
  logic signed [COORD_BITS-1:0] start_y;
  logic signed [COORD_BITS-1:0] ctrl_x;
  logic signed [COORD_BITS-1:0] ctrl_y;
  logic signed [COORD_BITS-1:0] end_x;
  logic signed [COORD_BITS-1:0] end_y;
  logic                         starts_path;

  modport source (output valid, rounded, start_x, start_y, ctrl_x, ctrl_y, end_x, end_y,
                  starts_path, input ready);
  modport sink   (input valid, rounded, start_x, start_y, ctrl_x, ctrl_y, end_x, end_y,
                  starts_path, output ready);
endinterface

`default_nettype wire

FILE: design/rounded_corner_points.sv
// Top level: fillet points of one polygon corner per transaction.
// Depends on rcp_pkg and the stream interfaces in rcp_ifs.sv.
//
//  channel   | kind        | contents
//  ----------+-------------+------------------------------------------
//  corners   | stream in   | prev/curr/next vertex, radius, first flag
//  fillets   | stream out  | rounded flag, start/ctrl/end, starts_path
//  apb       | APB slave   | default_radius at byte address 0
//
// One transaction enters per cycle while the pipeline is not held. The stages are:
// diff, abs, square, sum, COORD_BITS+1 square root steps, limit, product,
// COORD_BITS-1 divide steps and the final add. Reset (rst, synchronous)
// clears the valid bits and default_radius. The whole pipeline holds when
// the output register is full and not taken; nothing is lost or repeated.
`default_nettype none

module rounded_corner_points #(
  parameter int COORD_BITS = rcp_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = rcp_pkg::FRAC_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  rcp_corner_if.sink                         corners,
  rcp_fillet_if.source                       fillets,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [rcp_pkg::ADDR_BITS-1:0] paddr,
  input  wire logic [31:0]                   pwdata,
  output logic      [31:0]                   prdata,
  output logic                               pready
);
  import rcp_pkg::*;

  localparam int W      = COORD_BITS;
  localparam int DW     = W + 1;          // edge difference
  localparam int SW     = 2 * DW;         // sum of squares
  localparam int RW     = W - 1;          // radius
  localparam int LW     = W + 1;          // edge length
  localparam int QB     = W - 1;          // offset quotient bits
  localparam int PW     = DW + RW;        // |d| * radius
  localparam int REMS   = W + 4;          // square root remainder
  localparam int REMD   = W + 2;          // divide remainder
  localparam int SQ     = LW;             // square root steps
  localparam int MIN_LEN = ((1 << FRAC_BITS) + 999) / 1000;

  // context carried down the pipe
  typedef struct packed {
    logic signed [W-1:0]  cx;
    logic signed [W-1:0]  cy;
    logic [3:0][DW-1:0]   a;     // |dpx| |dpy| |dnx| |dny|
    logic [3:0]           neg;
    logic [RW-1:0]        r;
    logic                 f;
    logic [LW-1:0]        lp;
    logic [LW-1:0]        ln;
    logic                 sharp;
  } ctx_t;

  typedef struct packed {
    logic                   v;
    ctx_t                   c;
    logic [1:0][SW-1:0]     x;
    logic [1:0][REMS-1:0]   rem;
    logic [1:0][LW-1:0]     root;
  } sq_t;

  typedef struct packed {
    logic                   v;
    ctx_t                   c;
    logic [3:0][QB-1:0]     num;
    logic [3:0][REMD-1:0]   rem;
    logic [3:0][QB-1:0]     q;
  } dv_t;

  logic [RW-1:0] default_radius;
  logic          en;
  logic          addr_hit;

  // config register
  assign addr_hit = (paddr == ADDR_DEFAULT_RADIUS);
  assign pready   = 1'b1;
  assign prdata   = addr_hit ? 32'(default_radius) : 32'd0;
  always_ff @(posedge clk) begin
    if (rst) begin
      default_radius <= '0;
    end else if (psel && penable && pwrite && addr_hit) begin
      default_radius <= pwdata[RW-1:0];
    end
  end

  // global advance: hold while the output waits
  assign en            = !fillets.valid || fillets.ready;
  assign corners.ready = en;

  // stage 1: differences, radius select
  logic                  v1;
  ctx_t                  c1;
  ctx_t                  c1_next;
  logic [3:0][DW-1:0]    d1;
  always_comb begin
    c1_next    = '0;
    c1_next.cx = corners.curr_x;
    c1_next.cy = corners.curr_y;
    c1_next.f  = corners.first_corner;
    c1_next.r  = (corners.vertex_radius != '0) ? corners.vertex_radius : default_radius;
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= corners.valid;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      c1       <= c1_next;
      d1[0]    <= {corners.prev_x[W-1], corners.prev_x} - {corners.curr_x[W-1], corners.curr_x};
      d1[1]    <= {corners.prev_y[W-1], corners.prev_y} - {corners.curr_y[W-1], corners.curr_y};
      d1[2]    <= {corners.next_x[W-1], corners.next_x} - {corners.curr_x[W-1], corners.curr_x};
      d1[3]    <= {corners.next_y[W-1], corners.next_y} - {corners.curr_y[W-1], corners.curr_y};
    end
  end

  // stage 2: magnitudes and signs
  logic v2;
  ctx_t c2;
  ctx_t c2_next;
  always_comb begin
    c2_next = c1;
    for (int i = 0; i < 4; i++) begin
      c2_next.neg[i] = d1[i][DW-1];
      c2_next.a[i]   = d1[i][DW-1] ? DW'(-d1[i]) : d1[i];
    end
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      c2 <= c2_next;
    end
  end

  // stage 3: squares
  logic               v3;
  ctx_t               c3;
  logic [3:0][SW-1:0] p3;
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      c3 <= c2;
      for (int i = 0; i < 4; i++) begin
        p3[i] <= SW'(c2.a[i]) * SW'(c2.a[i]);
      end
    end
  end

  // stage 4: sums of squares, square root pipe entry
  sq_t sqp [SQ+1];
  always_ff @(posedge clk) begin
    if (rst) begin
      sqp[0].v <= 1'b0;
    end else if (en) begin
      sqp[0].v    <= v3;
      sqp[0].c    <= c3;
      sqp[0].x[0] <= p3[0] + p3[1];
      sqp[0].x[1] <= p3[2] + p3[3];
      sqp[0].rem  <= '0;
      sqp[0].root <= '0;
    end
  end

  // one root bit per stage, both edges in parallel
  function automatic sq_t sq_step(sq_t s);
    sq_t            o;
    logic [REMS-1:0] t;
    logic [REMS-1:0] tr;
    o = s;
    for (int j = 0; j < 2; j++) begin
      t  = {s.rem[j][REMS-3:0], s.x[j][SW-1:SW-2]};
      tr = REMS'({s.root[j], 2'b01});
      if (t >= tr) begin
        o.rem[j]  = t - tr;
        o.root[j] = {s.root[j][LW-2:0], 1'b1};
      end else begin
        o.rem[j]  = t;
        o.root[j] = {s.root[j][LW-2:0], 1'b0};
      end
      o.x[j] = {s.x[j][SW-3:0], 2'b00};
    end
    return o;
  endfunction

  for (genvar k = 0; k < SQ; k++) begin : g_sqrt
    always_ff @(posedge clk) begin
      if (rst) begin
        sqp[k+1].v <= 1'b0;
      end else if (en) begin
        sqp[k+1] <= sq_step(sqp[k]);
      end
    end
  end

  // limit stage: sharp test and radius clamp
  logic          vl;
  ctx_t          cl;
  ctx_t          cl_next;
  logic [LW-1:0] lp_w;
  logic [LW-1:0] ln_w;
  logic [LW-1:0] mn_w;
  logic [LW-1:0] lim_w;
  assign lp_w  = sqp[SQ].root[0];
  assign ln_w  = sqp[SQ].root[1];
  assign mn_w  = (lp_w < ln_w) ? lp_w : ln_w;
  assign lim_w = mn_w >> 1;
  always_comb begin
    cl_next       = sqp[SQ].c;
    cl_next.lp    = lp_w;
    cl_next.ln    = ln_w;
    cl_next.sharp = (sqp[SQ].c.r == '0) || (lp_w < LW'(MIN_LEN)) || (ln_w < LW'(MIN_LEN));
    cl_next.r     = (LW'(sqp[SQ].c.r) > lim_w) ? lim_w[RW-1:0] : sqp[SQ].c.r;
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      vl <= 1'b0;
    end else if (en) begin
      vl <= sqp[SQ].v;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      cl <= cl_next;
    end
  end

  // product stage: |d| * radius, divide pipe entry
  dv_t                dvp [QB+1];
  logic [3:0][PW-1:0] pr_w;
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      pr_w[i] = PW'(cl.a[i]) * PW'(cl.r);
    end
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      dvp[0].v <= 1'b0;
    end else if (en) begin
      dvp[0].v <= vl;
      dvp[0].c <= cl;
      dvp[0].q <= '0;
      for (int i = 0; i < 4; i++) begin
        dvp[0].num[i] <= pr_w[i][QB-1:0];
        dvp[0].rem[i] <= REMD'(pr_w[i][PW-1:QB]);
      end
    end
  end

  // one quotient bit per stage, four offsets in parallel
  function automatic dv_t dv_step(dv_t s);
    dv_t             o;
    logic [REMD-1:0] t;
    logic [REMD-1:0] dd;
    o = s;
    for (int j = 0; j < 4; j++) begin
      dd = (j < 2) ? REMD'(s.c.lp) : REMD'(s.c.ln);
      t  = {s.rem[j][REMD-2:0], s.num[j][QB-1]};
      if (t >= dd) begin
        o.rem[j] = t - dd;
        o.q[j]   = {s.q[j][QB-2:0], 1'b1};
      end else begin
        o.rem[j] = t;
        o.q[j]   = {s.q[j][QB-2:0], 1'b0};
      end
      o.num[j] = {s.num[j][QB-2:0], 1'b0};
    end
    return o;
  endfunction

  for (genvar k = 0; k < QB; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (rst) begin
        dvp[k+1].v <= 1'b0;
      end else if (en) begin
        dvp[k+1] <= dv_step(dvp[k]);
      end
    end
  end

  // final stage: signed offsets onto the corner, output register
  logic [3:0][W-1:0] pt_w;
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      logic [W-1:0] base;
      base    = (i % 2 == 0) ? dvp[QB].c.cx : dvp[QB].c.cy;
      pt_w[i] = dvp[QB].c.neg[i] ? (base - W'(dvp[QB].q[i])) : (base + W'(dvp[QB].q[i]));
    end
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      fillets.valid <= 1'b0;
    end else if (en) begin
      fillets.valid <= dvp[QB].v;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      fillets.rounded     <= !dvp[QB].c.sharp;
      fillets.ctrl_x      <= dvp[QB].c.cx;
      fillets.ctrl_y      <= dvp[QB].c.cy;
      fillets.start_x     <= dvp[QB].c.sharp ? dvp[QB].c.cx : pt_w[0];
      fillets.start_y     <= dvp[QB].c.sharp ? dvp[QB].c.cy : pt_w[1];
      fillets.end_x       <= dvp[QB].c.sharp ? dvp[QB].c.cx : pt_w[2];
      fillets.end_y       <= dvp[QB].c.sharp ? dvp[QB].c.cy : pt_w[3];
      fillets.starts_path <= dvp[QB].c.f;
    end
  end

endmodule

`default_nettype wire

FILE: verif/tb.sv
// Self-checking testbench for rounded_corner_points: corner stream in, fillet stream out.
// Depends on rcp_pkg, rcp_ifs.sv and the block; predicts fillets with exact arithmetic unless typed in.
`timescale 1ns / 1ps

module tb;
  import rcp_pkg::*;

  localparam int CB = 32;
  localparam int MIN_LEN = 66;
  localparam int LATENCY = 2 * CB + 7;

  // One expected fillet
  typedef struct packed {
    logic rounded;
    logic [CB-1:0] sx, sy, cx, cy, ex, ey;
    logic starts;
  } fillet_t;

  // One corner of the directed table; has_exp marks rows typed in by hand
  typedef struct {
    logic [CB-1:0] px, py, cx, cy, nx, ny;
    logic [CB-2:0] rad;
    logic first;
    logic has_exp;
    fillet_t exp_f;
  } corner_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_BITS-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  rcp_corner_if corners ();
  rcp_fillet_if fillets ();

  rounded_corner_points u_dut (
    .clk(clk), .rst(rst), .corners(corners), .fillets(fillets),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  fillet_t pending_fillets[$];
  logic [CB-2:0] shadow_radius;
  int errors = 0;
  int fillets_seen = 0;
  int rounded_seen = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;

  // Print one mismatch line and count it
  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    errors++;
    $display("tb: mismatch %s got %h expected %h (fillet %0d)", what, got, want, fillets_seen);
  endtask

  function automatic logic [63:0] isqrt(input logic [65:0] v);
    logic [63:0] root;
    logic [63:0] cand;
    root = '0;
    for (int b = 32; b >= 0; b--) begin
      cand = root | (64'd1 << b);
      if ({64'd0, cand} * {64'd0, cand} <= {62'd0, v}) root = cand;
    end
    return root;
  endfunction

  function automatic logic [63:0] mag(input logic signed [33:0] v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  // Arc point: corner plus edge scaled by radius over length, truncated toward zero
  function automatic logic [CB-1:0] arc_point(input logic signed [CB-1:0] c,
      input logic signed [33:0] d, input logic [63:0] r, input logic [63:0] len);
    logic [127:0] off;
    logic signed [65:0] v;
    off = ({64'd0, mag(d)} * {64'd0, r}) / {64'd0, len};
    v = d < 0 ? 66'(c) - 66'(off) : 66'(c) + 66'(off);
    return v[CB-1:0];
  endfunction

  function automatic fillet_t predict_fillet(input corner_row_t c);
    fillet_t f;
    logic signed [33:0] dpx, dpy, dnx, dny;
    logic [63:0] r, lp, ln, lim;
    dpx = 34'(signed'(c.px)) - 34'(signed'(c.cx));
    dpy = 34'(signed'(c.py)) - 34'(signed'(c.cy));
    dnx = 34'(signed'(c.nx)) - 34'(signed'(c.cx));
    dny = 34'(signed'(c.ny)) - 34'(signed'(c.cy));
    r = c.rad != 0 ? 64'(c.rad) : 64'(shadow_radius);
    f = '{1'b0, c.cx, c.cy, c.cx, c.cy, c.cx, c.cy, c.first};
    if (r == 0) return f;
    lp = isqrt(66'(mag(dpx) * mag(dpx)) + 66'(mag(dpy) * mag(dpy)));
    ln = isqrt(66'(mag(dnx) * mag(dnx)) + 66'(mag(dny) * mag(dny)));
    if (lp < MIN_LEN || ln < MIN_LEN) return f;
    lim = (lp < ln ? lp : ln) >> 1;
    if (r > lim) r = lim;
    f.rounded = 1'b1;
    f.sx = arc_point(c.cx, dpx, r, lp);
    f.sy = arc_point(c.cy, dpy, r, lp);
    f.ex = arc_point(c.cx, dnx, r, ln);
    f.ey = arc_point(c.cy, dny, r, ln);
    return f;
  endfunction

  // APB write, setup then access, then read back
  task automatic write_radius(input logic [CB-2:0] value);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= ADDR_DEFAULT_RADIUS; pwdata <= 32'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    pwrite <= 1'b0; penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[CB-2:0] != value) report("prdata", 64'(prdata), 64'(value));
    shadow_radius = value;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0;
  endtask

  // Called at a falling edge right after the last transaction
  task automatic drain_wait();
    corners.valid <= 1'b0;
    while (pending_fillets.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // Offer one corner and hold it until accepted
  task automatic send_corner(input corner_row_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      corners.valid <= 1'b0;
      @(negedge clk);
    end
    corners.valid <= 1'b1;
    corners.prev_x <= c.px; corners.prev_y <= c.py;
    corners.curr_x <= c.cx; corners.curr_y <= c.cy;
    corners.next_x <= c.nx; corners.next_y <= c.ny;
    corners.vertex_radius <= c.rad; corners.first_corner <= c.first;
    do @(posedge clk); while (!corners.ready);
    pending_fillets.push_back(c.has_exp ? c.exp_f : predict_fillet(c));
    @(negedge clk);
  endtask

  function automatic logic [CB-1:0] rand_coord(input int spread);
    case ($urandom_range(3))
      0: return $urandom();
      1: return 32'(signed'($urandom_range(2 * spread)) - spread);
      default: return 32'(signed'($urandom_range(2000000)) - 1000000);
    endcase
  endfunction

  function automatic corner_row_t rand_corner();
    corner_row_t c;
    int s;
    s = $urandom_range(3) == 0 ? 200 : 30000000;
    c.cx = rand_coord(s); c.cy = rand_coord(s);
    c.px = ($urandom_range(4) == 0) ? $urandom() : c.cx + rand_coord(s);
    c.py = ($urandom_range(4) == 0) ? $urandom() : c.cy + rand_coord(s);
    c.nx = ($urandom_range(4) == 0) ? $urandom() : c.cx + rand_coord(s);
    c.ny = ($urandom_range(4) == 0) ? $urandom() : c.cy + rand_coord(s);
    case ($urandom_range(3))
      0: c.rad = '0;
      1: c.rad = 31'($urandom());
      default: c.rad = 31'($urandom_range(2000000));
    endcase
    c.first = 1'($urandom_range(1));
    c.has_exp = 1'b0;
    c.exp_f = '0;
    return c;
  endfunction

  function automatic corner_row_t row(input logic [CB-1:0] px, py, cx, cy, nx, ny,
      input logic [CB-2:0] rad, input logic first);
    corner_row_t c;
    c = '{px, py, cx, cy, nx, ny, rad, first, 1'b0, '0};
    return c;
  endfunction

  // Sharp rows whose fillet is simply the corner repeated
  function automatic corner_row_t sharp_row(input corner_row_t c);
    c.has_exp = 1'b1;
    c.exp_f = '{1'b0, c.cx, c.cy, c.cx, c.cy, c.cx, c.cy, c.first};
    return c;
  endfunction

  // Output side: random stall, forced hold-off, compare with oldest expectation
  always @(negedge clk) begin
    if (rst) fillets.ready <= 1'b0;
    else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      fillets.ready <= 1'b0;
    end else fillets.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    fillet_t w;
    if (!rst && fillets.valid && fillets.ready) begin
      fillets_seen++;
      if (pending_fillets.size() == 0) begin
        report("unexpected fillet", 64'd0, 64'd0);
      end else begin
        w = pending_fillets.pop_front();
        rounded_seen += fillets.rounded;
        if (fillets.rounded !== w.rounded) report("rounded", 64'(fillets.rounded), 64'(w.rounded));
        if (fillets.start_x !== w.sx) report("start_x", 64'(fillets.start_x), 64'(w.sx));
        if (fillets.start_y !== w.sy) report("start_y", 64'(fillets.start_y), 64'(w.sy));
        if (fillets.ctrl_x !== w.cx) report("ctrl_x", 64'(fillets.ctrl_x), 64'(w.cx));
        if (fillets.ctrl_y !== w.cy) report("ctrl_y", 64'(fillets.ctrl_y), 64'(w.cy));
        if (fillets.end_x !== w.ex) report("end_x", 64'(fillets.end_x), 64'(w.ex));
        if (fillets.end_y !== w.ey) report("end_y", 64'(fillets.end_y), 64'(w.ey));
        if (fillets.starts_path !== w.starts)
          report("starts_path", 64'(fillets.starts_path), 64'(w.starts));
      end
    end
  end

  initial begin
    #400000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    corner_row_t table_rows[$];
    int phase_pct[4][2];
    corners.valid = 1'b0;
    corners.prev_x = '0; corners.prev_y = '0; corners.curr_x = '0; corners.curr_y = '0;
    corners.next_x = '0; corners.next_y = '0; corners.vertex_radius = '0;
    corners.first_corner = 1'b0;
    shadow_radius = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: after reset default radius is zero, so zero radius is sharp
    table_rows.push_back(sharp_row(row(32'h0010_0000, 0, 0, 0, 0, 32'h0010_0000, 0, 1)));
    table_rows.push_back(sharp_row(row(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
                                       32'h7fff_ffff, 0, 0, 0, 0)));
    // Short edges: previous edge, then next edge below the minimum length
    table_rows.push_back(sharp_row(row(65, 0, 0, 0, 32'h0010_0000, 0, 31'h7fff_ffff, 1)));
    table_rows.push_back(sharp_row(row(32'h0010_0000, 0, 0, 0, 0, 40, 31'h1_0000, 0)));
    table_rows.push_back(sharp_row(row(5, 5, 5, 5, 5, 5, 31'h7fff_ffff, 1)));
    table_rows.push_back(row(66, 0, 0, 0, 0, 66, 31'h7fff_ffff, 0));
    table_rows.push_back(row(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
                             32'h7fff_ffff, 32'h8000_0000, 31'h7fff_ffff, 1));
    table_rows.push_back(row(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                             32'h8000_0000, 32'h8000_0000, 1, 0));
    table_rows.push_back(row(32'hfff0_0000, 32'h0003_0000, 32'h0001_0000, 32'hffff_0000,
                             32'h0005_0000, 32'h0009_0000, 31'h0000_8000, 1));
    table_rows.push_back(row(32'hffff_ffff, 32'hffff_ffff, 32'h0000_1000, 32'h0000_2000,
                             32'h8000_0001, 32'h7fff_fffe, 31'h5555_5555, 0));
    foreach (table_rows[i]) send_corner(table_rows[i]);
    drain_wait();

    // Rounded corners again with the maximum default radius, then the first corner with radius one
    write_radius(31'h7fff_ffff);
    for (int i = 5; i < table_rows.size(); i++) begin
      table_rows[i].rad = '0;
      send_corner(table_rows[i]);
    end
    drain_wait();
    write_radius(31'd1);
    send_corner(row(32'h0010_0000, 0, 0, 0, 0, 32'h0010_0000, 0, 1));
    drain_wait();

    // Random phases: none, sender idle, receiver stall, both
    phase_pct = '{'{0, 0}, '{66, 0}, '{0, 66}, '{21, 21}};
    for (int p = 0; p < 4; p++) begin
      write_radius(p == 3 ? 31'h7fff_ffff : 31'($urandom()));
      send_idle_pct = phase_pct[p][0];
      recv_stall_pct = phase_pct[p][1];
      if (p == 0) hold_cycles <= 300;
      for (int i = 0; i < 110; i++) send_corner(rand_corner());
      drain_wait();
    end
    write_radius('0);
    send_idle_pct = 0; recv_stall_pct = 0;
    for (int i = 0; i < 20; i++) send_corner(rand_corner());
    drain_wait();

    $display("tb: %0d fillets checked, %0d rounded, default radius swept 0..max",
             fillets_seen, rounded_seen);
    $display("tb: phases without idling, with sender gaps, receiver stalls and a long hold-off");
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule

FILE: files.f
design/rcp_pkg.sv
design/rcp_ifs.sv
design/rounded_corner_points.sv
verif/tb.sv
